FILE: rtl/lbr_pkg.sv
// Shared types and constants of the label boundary refinement block.
package lbr_pkg;

  localparam int LABEL_W        = 7;
  localparam int COORD_W        = 16;
  localparam int NB_COUNT       = 8;
  localparam int NB_IDX_W       = $clog2(NB_COUNT);
  localparam int CNT_W          = $clog2(NB_COUNT + 1);
  localparam int DIFF_W         = COORD_W + 1;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int DIST_W         = 36;
  localparam int MAX_LABELS_DEF = 64;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_REFINE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] lab_l;
    logic signed [COORD_W-1:0] lab_a;
    logic signed [COORD_W-1:0] lab_b;
  } lab_t;

  typedef struct packed {
    logic                      operation;
    logic [LABEL_W-1:0]        label;
    logic signed [COORD_W-1:0] lab_l;
    logic signed [COORD_W-1:0] lab_a;
    logic signed [COORD_W-1:0] lab_b;
    logic [NB_COUNT*LABEL_W-1:0] neighbor_labels;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] new_label;
    logic               changed;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic [LABEL_W-1:0] label;
  } cand_t;

  typedef struct packed {
    cand_t             tag;
    logic [DIST_W-1:0] distance;
  } dist_res_t;

endpackage

FILE: rtl/lbr_center_mem.sv
// Color center store with one write port and one registered read port.
module lbr_center_mem #(
  parameter int MaxLabels = lbr_pkg::MAX_LABELS_DEF,
  parameter int AddrW     = $clog2(MaxLabels)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  lbr_pkg::lab_t     wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output lbr_pkg::lab_t     rdata_o
);
  import lbr_pkg::*;

  lab_t mem_q [MaxLabels];
  lab_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lbr_dist_unit.sv
// Shared pipelined squared Lab distance unit with candidate tags.
module lbr_dist_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbr_pkg::lab_t       pixel_i,
  input  lbr_pkg::cand_t      req_i,
  input  lbr_pkg::lab_t       center_i,
  output lbr_pkg::dist_res_t  res_o,
  output logic                busy_o
);
  import lbr_pkg::*;

  cand_t tag0_q, tag1_q, tag2_q, tag3_q;
  logic signed [DIFF_W-1:0] dl_q, da_q, db_q;
  logic signed [2*DIFF_W-1:0] pl, pa, pb;
  logic [SQ_W-1:0] sl_q, sa_q, sb_q;
  logic [DIST_W-1:0] dist_q;

  assign pl = dl_q * dl_q;
  assign pa = da_q * da_q;
  assign pb = db_q * db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag0_q <= req_i;
      tag1_q <= tag0_q;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q   <= DIFF_W'(pixel_i.lab_l) - DIFF_W'(center_i.lab_l);
    da_q   <= DIFF_W'(pixel_i.lab_a) - DIFF_W'(center_i.lab_a);
    db_q   <= DIFF_W'(pixel_i.lab_b) - DIFF_W'(center_i.lab_b);
    sl_q   <= pl[SQ_W-1:0];
    sa_q   <= pa[SQ_W-1:0];
    sb_q   <= pb[SQ_W-1:0];
    dist_q <= DIST_W'(sl_q) + DIST_W'(sa_q) + DIST_W'(sb_q);
  end

  assign res_o.tag      = tag3_q;
  assign res_o.distance = dist_q;
  assign busy_o     = tag0_q.valid | tag1_q.valid | tag2_q.valid | tag3_q.valid;

endmodule

FILE: rtl/lbr_seq.sv
// Sequencer that issues the candidate labels, keeps the best one and holds the result.
module lbr_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  lbr_pkg::in_t            in_data_i,
  output logic                    in_stall_o,
  output lbr_pkg::out_t           out_data_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [lbr_pkg::LABEL_W-1:0] limit_i,
  output lbr_pkg::lab_t           pixel_o,
  output lbr_pkg::cand_t          req_o,
  input  lbr_pkg::dist_res_t      res_i,
  input  logic                    busy_i
);
  import lbr_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LABEL_W-1:0] lid_q, lid_d;
  logic [LABEL_W-1:0] best_q, best_d;
  logic [DIST_W-1:0] bdist_q, bdist_d;
  logic [NB_COUNT-1:0][LABEL_W-1:0] nb_q, nb_d;
  lab_t pix_q, pix_d;
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic [NB_IDX_W-1:0] nb_idx;
  logic [LABEL_W-1:0] cand_label;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign nb_idx = NB_IDX_W'(cnt_q - CNT_W'(1));
  assign cand_label = (cnt_q == '0) ? lid_q : nb_q[nb_idx];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lid_d       = lid_q;
    best_d      = best_q;
    bdist_d     = bdist_q;
    nb_d        = nb_q;
    pix_d       = pix_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    req_o       = '0;

    if (res_i.tag.valid && (res_i.tag.first || (res_i.distance < bdist_q))) begin
      best_d  = res_i.tag.label;
      bdist_d = res_i.distance;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.operation == OP_REFINE)) begin
          lid_d       = in_data_i.label;
          best_d      = in_data_i.label;
          nb_d        = in_data_i.neighbor_labels;
          pix_d.lab_l = in_data_i.lab_l;
          pix_d.lab_a = in_data_i.lab_a;
          pix_d.lab_b = in_data_i.lab_b;
          cnt_d       = '0;
          state_d     = (in_data_i.label < limit_i) ? ST_ISSUE : ST_FINISH;
        end
      end
      ST_ISSUE: begin
        req_o.valid = cand_label < limit_i;
        req_o.first = cnt_q == '0;
        req_o.label = cand_label;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NB_COUNT)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.new_label = best_q;
          out_d.changed   = best_q != lid_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lid_q   <= lid_d;
    best_q  <= best_d;
    bdist_q <= bdist_d;
    nb_q    <= nb_d;
    pix_q   <= pix_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pixel_o     = pix_q;

endmodule

FILE: rtl/label_boundary_refine_unit.sv
// Top level of the label boundary refinement block.
// A center load transaction writes its center into the store. A pixel transaction whose own label is
// valid occupies the block from acceptance to the next acceptance: nine candidate slots go one
// per cycle through the single center store read port and the shared distance pipeline, which
// then drains before the result is written to the output register. A pixel with an invalid
// label skips the candidate slots and goes straight to the output register. A result waiting in
// the output register does not hold off the next transaction, only the next result.
module label_boundary_refine_unit #(
  parameter int MaxLabels = lbr_pkg::MAX_LABELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lbr_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lbr_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [lbr_pkg::LABEL_W-1:0]  cfg_wdata_i
);
  import lbr_pkg::*;

  localparam int AddrW = $clog2(MaxLabels);

  logic [LABEL_W-1:0] label_count_q;
  logic [LABEL_W-1:0] limit;
  logic mem_we;
  lab_t in_lab, pixel, center;
  cand_t req;
  dist_res_t dres;
  logic busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= '0;
    end else if (cfg_we_i) begin
      label_count_q <= cfg_wdata_i;
    end
  end

  assign limit = (label_count_q < LABEL_W'(MaxLabels)) ? label_count_q : LABEL_W'(MaxLabels);

  assign mem_we = in_valid_i && !in_stall_o && (in_data_i.operation == OP_LOAD) &&
                  (in_data_i.label < LABEL_W'(MaxLabels));
  assign in_lab.lab_l = in_data_i.lab_l;
  assign in_lab.lab_a = in_data_i.lab_a;
  assign in_lab.lab_b = in_data_i.lab_b;

  lbr_center_mem #(
    .MaxLabels (MaxLabels),
    .AddrW     (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_data_i.label[AddrW-1:0]),
    .wdata_i (in_lab),
    .re_i    (req.valid),
    .raddr_i (req.label[AddrW-1:0]),
    .rdata_o (center)
  );

  lbr_dist_unit u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pixel),
    .req_i    (req),
    .center_i (center),
    .res_o    (dres),
    .busy_o   (busy)
  );

  lbr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .limit_i     (limit),
    .pixel_o     (pixel),
    .req_o       (req),
    .res_i       (dres),
    .busy_i      (busy)
  );

  a_refine_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == OP_REFINE) |=> in_stall_o)
    else $error("Pixel transaction did not occupy the block.");

  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |-> in_stall_o && !mem_we)
    else $error("Center read issued while the block was idle.");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dres.tag.valid |-> in_stall_o)
    else $error("Distance result arrived outside a pixel transaction.");

endmodule
